// File: rtl/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types and constants for the keyword substitution cipher engine.
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int TABLE_DEPTH       = 26;
    localparam int IDX_W             = 5;
    localparam logic [7:0] FIRST_LETTER = 8'd65;

    typedef enum logic [2:0] {
        ACT_KEY     = 3'd0,
        ACT_FINISH  = 3'd1,
        ACT_ENCRYPT = 3'd2,
        ACT_DECRYPT = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_FILL = 1'b1
    } key_state_t;

    // One table write request.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } tbl_wr_t;

endpackage

// File: rtl/kwsc_ram.sv
// ----------------------------------------------------------------------------
// kwsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kwsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kwsc_ctrl.sv
// ----------------------------------------------------------------------------
// kwsc_ctrl
// Key builder: used flags, fill count, ready flag and the finish walk.
// Issues the write requests for both tables.
// ----------------------------------------------------------------------------
module kwsc_ctrl #(
    parameter int ALPHABET_SIZE = kwsc_pkg::ALPHABET_SIZE_DEF,
    parameter int AW            = $clog2(ALPHABET_SIZE),
    parameter int CW            = $clog2(ALPHABET_SIZE + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_accept,
    input  kwsc_pkg::action_t req_action,
    input  logic              letter_ok,
    input  logic [AW-1:0]     letter_idx,
    output kwsc_pkg::tbl_wr_t cipher_wr,
    output kwsc_pkg::tbl_wr_t inverse_wr,
    output logic              key_ready,
    output logic              busy
);

    kwsc_pkg::key_state_t state_reg, state_next;
    logic [ALPHABET_SIZE-1:0] used_reg, used_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic                     ready_reg, ready_next;
    logic [AW-1:0]            walk_reg, walk_next;

    logic          place_req;
    logic [AW-1:0] place_idx;
    logic          do_place;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kwsc_pkg::ST_IDLE;
            used_reg  <= '0;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
            walk_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
            walk_reg  <= walk_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        walk_next  = walk_reg;
        place_req  = 1'b0;
        place_idx  = letter_idx;

        case (state_reg)
            kwsc_pkg::ST_IDLE: begin
                if (req_accept) begin
                    case (req_action)
                        kwsc_pkg::ACT_KEY: begin
                            place_req = !ready_reg && letter_ok;
                        end
                        kwsc_pkg::ACT_FINISH: begin
                            if (!ready_reg) begin
                                state_next = kwsc_pkg::ST_FILL;
                                walk_next  = AW'(ALPHABET_SIZE - 1);
                            end
                        end
                        kwsc_pkg::ACT_CLEAR: begin
                            used_next  = '0;
                            fill_next  = '0;
                            ready_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kwsc_pkg::ST_FILL: begin
                // walk from the highest letter down, placing every unused one
                place_req = 1'b1;
                place_idx = walk_reg;
                if (walk_reg == '0) begin
                    ready_next = 1'b1;
                    state_next = kwsc_pkg::ST_IDLE;
                end else begin
                    walk_next = walk_reg - 1'b1;
                end
            end
            default: begin
                state_next = kwsc_pkg::ST_IDLE;
            end
        endcase

        do_place = place_req && !used_reg[place_idx]
                   && (fill_reg < CW'(ALPHABET_SIZE));
        if (do_place) begin
            used_next[place_idx] = 1'b1;
            fill_next            = fill_reg + 1'b1;
        end
    end

    assign cipher_wr.we    = do_place;
    assign cipher_wr.addr  = kwsc_pkg::IDX_W'(fill_reg);
    assign cipher_wr.data  = kwsc_pkg::IDX_W'(place_idx);
    assign inverse_wr.we   = do_place;
    assign inverse_wr.addr = kwsc_pkg::IDX_W'(place_idx);
    assign inverse_wr.data = kwsc_pkg::IDX_W'(fill_reg);

    assign key_ready = ready_reg;
    assign busy      = (state_reg != kwsc_pkg::ST_IDLE);

endmodule

// File: rtl/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword cipher engine: builds a substitution alphabet from a keyword and
// translates characters through it in both directions.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the action (keyword
//   letter, finish key, encrypt, decrypt, clear key), s_tdata the byte.
//   Only encrypt and decrypt requests give a result on the m_ stream:
//   m_tdata is the translated or passed byte, m_tuser flags pass-through
//   and whether the key was ready.
//   A result passes through the registered table read and then the
//   output register before it appears on the m_ stream.
//   Throughput: keyword, clear, encrypt and decrypt requests are taken one
//   per cycle while the output is not stalled. A finish request walks the
//   alphabet: s_tready stays low while every unused letter is placed.
//   Both tables sit in RAMs with one write and one read port; the read port
//   serves translation, the write port the key builder, never at once.
//   Reset clears the used flags, fill count, ready flag and output valid;
//   table contents are not cleared and are only used once a key is ready.
//   When the receiver stalls, the output register holds its result and one
//   more result may wait in the read stage; after that s_tready drops.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher #(
    parameter int ALPHABET_SIZE = kwsc_pkg::ALPHABET_SIZE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] letter
    input  logic [2:0] s_tuser,   // [2:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser    // [0] passed_through, [1] key_ready
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);
    localparam logic [8:0] LETTER_END = 9'(kwsc_pkg::FIRST_LETTER) + 9'(ALPHABET_SIZE);

    kwsc_pkg::action_t act;
    logic              s_accept;
    logic              is_xlate;
    logic              letter_ok;
    logic [AW-1:0]     letter_idx;

    kwsc_pkg::tbl_wr_t cipher_wr, inverse_wr;
    logic              key_ready;
    logic              busy;

    logic [kwsc_pkg::IDX_W-1:0] cipher_rd, inverse_rd, sel_rd;

    // read stage
    logic       p_valid_reg, p_valid_next;
    logic       p_pass_reg;
    logic [7:0] p_byte_reg;
    logic       p_dec_reg;
    logic       p_ready_reg;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic [1:0] m_user_reg;
    logic       m_free;
    logic       m_load;

    assign act      = kwsc_pkg::action_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign is_xlate = (act == kwsc_pkg::ACT_ENCRYPT) || (act == kwsc_pkg::ACT_DECRYPT);

    assign letter_ok  = (s_tdata >= kwsc_pkg::FIRST_LETTER) && ({1'b0, s_tdata} < LETTER_END);
    assign letter_idx = AW'(s_tdata - kwsc_pkg::FIRST_LETTER);

    assign m_free   = !m_valid_reg || m_tready;
    assign m_load   = p_valid_reg && m_free;
    // hold off while the finish walk runs or the read stage cannot drain
    assign s_tready = !busy && (!p_valid_reg || m_free);

    kwsc_ctrl #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .AW            (AW),
        .CW            (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (s_accept),
        .req_action (act),
        .letter_ok  (letter_ok),
        .letter_idx (letter_idx),
        .cipher_wr  (cipher_wr),
        .inverse_wr (inverse_wr),
        .key_ready  (key_ready),
        .busy       (busy)
    );

    kwsc_ram #(
        .WIDTH (kwsc_pkg::IDX_W),
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW)
    ) u_cipher_ram (
        .aclk  (aclk),
        .we    (cipher_wr.we),
        .waddr (cipher_wr.addr[AW-1:0]),
        .wdata (cipher_wr.data),
        .re    (s_accept && is_xlate),
        .raddr (letter_idx),
        .rdata (cipher_rd)
    );

    kwsc_ram #(
        .WIDTH (kwsc_pkg::IDX_W),
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW)
    ) u_inverse_ram (
        .aclk  (aclk),
        .we    (inverse_wr.we),
        .waddr (inverse_wr.addr[AW-1:0]),
        .wdata (inverse_wr.data),
        .re    (s_accept && is_xlate),
        .raddr (letter_idx),
        .rdata (inverse_rd)
    );

    // Read stage: capture request info while the tables are read.
    always_comb begin
        p_valid_next = p_valid_reg;
        if (s_accept && is_xlate) begin
            p_valid_next = 1'b1;
        end else if (m_load) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_xlate) begin
            p_pass_reg  <= !(key_ready && letter_ok);
            p_byte_reg  <= s_tdata;
            p_dec_reg   <= (act == kwsc_pkg::ACT_DECRYPT);
            p_ready_reg <= key_ready;
        end
    end

    // Output register: hold the result until the receiver takes it.
    assign sel_rd = p_dec_reg ? inverse_rd : cipher_rd;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_data_reg <= p_pass_reg ? p_byte_reg
                                     : kwsc_pkg::FIRST_LETTER + 8'(sel_rd);
            m_user_reg <= {p_ready_reg, p_pass_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: rtl/kwsc_checker.sv
// ----------------------------------------------------------------------------
// kwsc_checker
// Port-level checks for the keyword substitution cipher engine.
// ----------------------------------------------------------------------------
module kwsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [2:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // translation only with a ready key
    a_xlate_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1])
        else $error("translated without a ready key");

    // translated output is an uppercase letter
    a_xlate_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata >= 8'd65) && (m_tdata <= 8'd90))
        else $error("translated output outside the alphabet");

    // a rising result needs reset to have been released earlier
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn, 2))
        else $error("result right after reset");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
